### rtl/midi_zone_split_layer_mapper_core_assert.svh
// Assertion macros for the zone mapper checker.
`ifndef MIDI_ZONE_SPLIT_LAYER_MAPPER_CORE_ASSERT_SVH
`define MIDI_ZONE_SPLIT_LAYER_MAPPER_CORE_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define MZSLM_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that holds in and out of reset.
`define MZSLM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mzslm_pkg.sv
// Types and constants for the MIDI zone split/layer mapper.
package mzslm_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_W     = 63;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = 6;
  localparam int ADDR_LSB  = 3;
  localparam int PDATA_W   = 64;

  localparam int KEY_W  = 7;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int CH_W   = 4;

  localparam logic [REG_W-1:0] ZONE0_RESET = 63'd36099165763149697;

  localparam logic signed [9:0] NOTE_MAX = 10'sd127;
  localparam logic signed [9:0] VEL_MAX  = 10'sd127;
  localparam logic signed [9:0] VEL_MIN  = 10'sd1;

  // Zone register layout, top bit first.
  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  offset;
    logic [7:0]  gain;
    logic [7:0]  tr2;
    logic [7:0]  tr1;
    logic        stack;
    logic        l2_en;
    logic [3:0]  ch2;
    logic [3:0]  ch1;
    logic [5:0]  kmax;
    logic [5:0]  kmin;
    logic        enable;
  } zone_t;

  typedef struct packed {
    logic  found;
    zone_t zone;
  } pick_t;

  typedef struct packed {
    logic [VEL_W-1:0]  velocity;
    logic [NOTE_W-1:0] note;
    logic [CH_W-1:0]   channel;
  } layer_t;

  typedef struct packed {
    logic   two;
    layer_t l1;
    layer_t l2;
  } layer_pair_t;

endpackage

### rtl/mzslm_zone_pick.sv
// Priority zone lookup: best enabled zone whose key range holds the key.
module mzslm_zone_pick #(
  parameter int ZONE_COUNT = 8
) (
  input  mzslm_pkg::zone_t zones [mzslm_pkg::REG_COUNT],
  input  logic [mzslm_pkg::KEY_W-1:0] key,
  output mzslm_pkg::pick_t pick
);
  import mzslm_pkg::*;

  always_comb begin
    logic       found;
    logic [7:0] best;
    zone_t      win;
    logic       hit;
    found = 1'b0;
    best  = '0;
    win   = '0;
    for (int i = 0; i < ZONE_COUNT; i++) begin
      hit = zones[i].enable &&
            key >= {1'b0, zones[i].kmin} && key <= {1'b0, zones[i].kmax};
      // strict compare keeps the lower index on equal priority
      if (hit && (!found || zones[i].prio > best)) begin
        found = 1'b1;
        best  = zones[i].prio;
        win   = zones[i];
      end
    end
    pick.found = found;
    pick.zone  = win;
  end

endmodule

### rtl/mzslm_layer_calc.sv
// Velocity scaling and per-layer note transpose for the selected zone.
module mzslm_layer_calc (
  input  mzslm_pkg::zone_t zone,
  input  logic [mzslm_pkg::NOTE_W-1:0] note,
  input  logic [mzslm_pkg::VEL_W-1:0]  vel,
  output mzslm_pkg::layer_pair_t pair
);
  import mzslm_pkg::*;

  logic [14:0]        prod;
  logic [7:0]         scaled;
  logic signed [9:0]  vel_sum;
  logic [VEL_W-1:0]   vel_sat;
  logic signed [9:0]  n1_sum;
  logic signed [9:0]  n2_sum;
  logic [NOTE_W-1:0]  n1_sat;
  logic [NOTE_W-1:0]  n2_sat;

  assign prod    = {8'b0, vel} * {7'b0, zone.gain};
  assign scaled  = prod[14:7];
  assign vel_sum = $signed({2'b0, scaled}) + $signed({{2{zone.offset[7]}}, zone.offset});
  assign n1_sum  = $signed({3'b0, note}) + $signed({{2{zone.tr1[7]}}, zone.tr1});
  assign n2_sum  = $signed({3'b0, note}) + $signed({{2{zone.tr2[7]}}, zone.tr2});

  always_comb begin
    if (vel_sum < VEL_MIN) begin
      vel_sat = VEL_MIN[VEL_W-1:0];
    end else if (vel_sum > VEL_MAX) begin
      vel_sat = VEL_MAX[VEL_W-1:0];
    end else begin
      vel_sat = vel_sum[VEL_W-1:0];
    end

    if (n1_sum < 0) begin
      n1_sat = '0;
    end else if (n1_sum > NOTE_MAX) begin
      n1_sat = NOTE_MAX[NOTE_W-1:0];
    end else begin
      n1_sat = n1_sum[NOTE_W-1:0];
    end

    if (n2_sum < 0) begin
      n2_sat = '0;
    end else if (n2_sum > NOTE_MAX) begin
      n2_sat = NOTE_MAX[NOTE_W-1:0];
    end else begin
      n2_sat = n2_sum[NOTE_W-1:0];
    end
  end

  assign pair.two         = zone.stack || zone.l2_en || (zone.tr2 != 8'd0) ||
                            (zone.ch2 != zone.ch1);
  assign pair.l1.channel  = zone.ch1;
  assign pair.l1.note     = n1_sat;
  assign pair.l1.velocity = vel_sat;
  assign pair.l2.channel  = zone.ch2;
  assign pair.l2.note     = n2_sat;
  assign pair.l2.velocity = vel_sat;

endmodule

### rtl/midi_zone_split_layer_mapper_core.sv
// Top level of the MIDI zone split/layer mapper.
//
// Input stream (s_*): one item per note event, tdata = split key, note, velocity.
// Output stream (m_*): one or two layer items per matched event, tdata = channel,
// note, velocity; tlast marks the final layer of an event. Events whose key hits
// no enabled zone give no output.
// Zones are set through the APB port, one 63-bit register per zone at 8*index.
// Write zones only while the stream is idle.
// Each event passes the input register, then the result register, before its first
// layer shows on m_tvalid. An event with two layers holds the output port for both
// items; the single output port sets the sustained rate. The input register
// accepts a new item in every cycle in which it is empty or can hand its item on
// or drop it. When m_tready is low the result register holds its item, and an
// input item that hits a zone stays in the input register with s_tready low.
// Reset empties both registers and loads the default zone set (zone 0 enabled
// over keys 0..63, all other zones disabled).
module midi_zone_split_layer_mapper_core #(
  parameter int ZONE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [6:0] split_key, [13:7] note_in, [20:14] velocity_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] channel_out, [10:4] note_out, [17:11] velocity_out
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mzslm_pkg::ADDR_W-1:0]  paddr,
  input  logic [mzslm_pkg::PDATA_W-1:0] pwdata,
  output logic [mzslm_pkg::PDATA_W-1:0] prdata,
  output logic        pready
);
  import mzslm_pkg::*;

  zone_t              zones [REG_COUNT];
  logic [REG_IDX_W-1:0] reg_idx;

  logic               a_valid;
  logic [KEY_W-1:0]   a_key;
  logic [NOTE_W-1:0]  a_note;
  logic [VEL_W-1:0]   a_vel;
  logic               a_move;

  pick_t              pick;
  layer_pair_t        pair;

  logic               b_valid;
  logic               b_phase;
  layer_pair_t        b_pair;
  logic               b_free;
  layer_t             cur;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_LSB +: REG_IDX_W];
  assign prdata  = {1'b0, zones[reg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      zones[0] <= zone_t'(ZONE0_RESET);
      for (int i = 1; i < REG_COUNT; i++) begin
        zones[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      zones[reg_idx] <= zone_t'(pwdata[REG_W-1:0]);
    end
  end

  // input register
  assign b_free   = !b_valid || (m_tready && m_tlast);
  assign a_move   = a_valid && (!pick.found || b_free);
  assign s_tready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_key  <= s_tdata[6:0];
      a_note <= s_tdata[13:7];
      a_vel  <= s_tdata[20:14];
    end
  end

  mzslm_zone_pick #(
    .ZONE_COUNT(ZONE_COUNT)
  ) u_pick (
    .zones(zones),
    .key  (a_key),
    .pick (pick)
  );

  mzslm_layer_calc u_calc (
    .zone(pick.zone),
    .note(a_note),
    .vel (a_vel),
    .pair(pair)
  );

  // result register: emit layer one, then layer two if present
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_phase <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid && pick.found;
      b_phase <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      b_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid && pick.found) begin
      b_pair <= pair;
    end
  end

  assign cur      = b_phase ? b_pair.l2 : b_pair.l1;
  assign m_tvalid = b_valid;
  assign m_tlast  = !b_pair.two || b_phase;
  assign m_tdata  = {6'b0, cur};

endmodule

### rtl/mzslm_checker.sv
// Port-level checker for the zone mapper, bound to the top level.
`include "midi_zone_split_layer_mapper_core_assert.svh"

module mzslm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        pready
);

  `MZSLM_ASSERT_RST(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")
  `MZSLM_ASSERT_RST(a_vel_floor, clk, rst, m_tvalid |-> m_tdata[17:11] != 7'd0, "velocity below one")
  `MZSLM_ASSERT_RST(a_layer_two_follows, clk, rst, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "second layer missing")
  `MZSLM_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

endmodule

bind midi_zone_split_layer_mapper_core mzslm_checker u_mzslm_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .pready  (pready)
);
